[sv/pctd_pkg.sv]
// ----------------------------------------------------------------------------
// pctd_pkg: shared types and constants of the percent escape decoder
// word formats, status codes, character codes and reset limit
// ----------------------------------------------------------------------------
package pctd_pkg;

  // width of the length limit register and of the produced-byte count
  localparam int unsigned LEN_W = 13;

  // reset value of the limit register
  localparam logic [LEN_W-1:0] MAX_LEN = 13'd4096;

  // most result words that one input word can give
  localparam int unsigned RES_DEPTH = 3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  // character codes
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       out_last;
  } out_word_t;

  // decoder state carried from one input word to the next
  typedef struct packed {
    logic [1:0]       held_count;
    logic [3:0]       held_high_nibble;
    logic             held_lower;
    logic [LEN_W-1:0] emitted_count;
    logic             discarding;
  } dec_state_t;

endpackage

[sv/pctd_step.sv]
// ----------------------------------------------------------------------------
// pctd_step: one decode step
// maps the current state and one input word to up to three result words
// and the next state
// ----------------------------------------------------------------------------
module pctd_step (
  input  pctd_pkg::dec_state_t                      cur,
  input  logic [pctd_pkg::LEN_W-1:0]                max_out_len,
  input  pctd_pkg::in_word_t                        word,
  output logic [1:0]                                res_n,
  output pctd_pkg::out_word_t [pctd_pkg::RES_DEPTH-1:0] res,
  output pctd_pkg::dec_state_t                      nxt
);
  import pctd_pkg::*;

  logic       is_hex;
  logic [3:0] hex_val;
  logic [7:0] digit_ch;
  logic [7:0] dec_byte;

  // hex digit of either case
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'h0;
    if (word.in_byte >= 8'h30 && word.in_byte <= 8'h39) begin
      hex_val = word.in_byte[3:0];
    end else if (word.in_byte >= 8'h61 && word.in_byte <= 8'h66) begin
      hex_val = 4'(word.in_byte - 8'h57);
    end else if (word.in_byte >= 8'h41 && word.in_byte <= 8'h46) begin
      hex_val = 4'(word.in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // held digit restored in its original case
  always_comb begin
    if (cur.held_high_nibble < 4'd10) begin
      digit_ch = 8'h30 + {4'h0, cur.held_high_nibble};
    end else begin
      digit_ch = (cur.held_lower ? 8'h61 : 8'h41) + {4'h0, cur.held_high_nibble} - 8'd10;
    end
  end

  assign dec_byte = {cur.held_high_nibble, hex_val};

  function automatic logic no_room(input logic [LEN_W:0] e, input logic [LEN_W-1:0] m);
    return (e + (LEN_W+1)'(1)) >= {1'b0, m};
  endfunction

  always_comb begin
    logic [LEN_W:0] e;
    logic [1:0]     n;
    logic           ok;
    logic           done;
    logic           skip;

    e    = {1'b0, cur.emitted_count};
    n    = 2'd0;
    ok   = 1'b1;
    done = 1'b0;
    skip = 1'b0;
    res  = '0;
    nxt  = cur;

    if (cur.discarding) begin
      skip = 1'b1;
      if (word.in_last) begin
        nxt = '0;
      end
    end else begin
      if (cur.held_count == 2'd2) begin
        nxt.held_count = 2'd0;
        if (is_hex) begin
          // complete escape: length check first, then zero check
          done = 1'b1;
          if (no_room(e, max_out_len)) begin
            res[n] = '{out_byte: CH_NUL, status: ST_TOO_LONG, out_last: 1'b1};
            n  = n + 2'd1;
            ok = 1'b0;
          end else if (dec_byte == CH_NUL) begin
            res[n] = '{out_byte: CH_NUL, status: ST_ZERO, out_last: 1'b1};
            n  = n + 2'd1;
            ok = 1'b0;
          end else begin
            res[n] = '{out_byte: dec_byte, status: ST_OK, out_last: 1'b0};
            n = n + 2'd1;
            e = e + (LEN_W+1)'(1);
          end
        end else begin
          // malformed: flush the percent sign and the held digit
          if (no_room(e, max_out_len)) begin
            res[n] = '{out_byte: CH_NUL, status: ST_TOO_LONG, out_last: 1'b1};
            n  = n + 2'd1;
            ok = 1'b0;
          end else begin
            res[n] = '{out_byte: CH_PCT, status: ST_OK, out_last: 1'b0};
            n = n + 2'd1;
            e = e + (LEN_W+1)'(1);
          end
          if (ok) begin
            if (no_room(e, max_out_len)) begin
              res[n] = '{out_byte: CH_NUL, status: ST_TOO_LONG, out_last: 1'b1};
              n  = n + 2'd1;
              ok = 1'b0;
            end else begin
              res[n] = '{out_byte: digit_ch, status: ST_OK, out_last: 1'b0};
              n = n + 2'd1;
              e = e + (LEN_W+1)'(1);
            end
          end
        end
      end else if (cur.held_count == 2'd1) begin
        if (is_hex && !word.in_last) begin
          nxt.held_count       = 2'd2;
          nxt.held_high_nibble = hex_val;
          nxt.held_lower       = (word.in_byte >= 8'h61);
          skip                 = 1'b1;
        end else begin
          nxt.held_count = 2'd0;
          if (no_room(e, max_out_len)) begin
            res[n] = '{out_byte: CH_NUL, status: ST_TOO_LONG, out_last: 1'b1};
            n  = n + 2'd1;
            ok = 1'b0;
          end else begin
            res[n] = '{out_byte: CH_PCT, status: ST_OK, out_last: 1'b0};
            n = n + 2'd1;
            e = e + (LEN_W+1)'(1);
          end
        end
      end

      // the current byte itself
      if (!skip && ok && !done) begin
        if (word.in_byte == CH_PCT && !word.in_last) begin
          nxt.held_count = 2'd1;
        end else if (no_room(e, max_out_len)) begin
          res[n] = '{out_byte: CH_NUL, status: ST_TOO_LONG, out_last: 1'b1};
          n  = n + 2'd1;
          ok = 1'b0;
        end else begin
          res[n] = '{out_byte: word.in_byte, status: ST_OK, out_last: 1'b0};
          n = n + 2'd1;
          e = e + (LEN_W+1)'(1);
        end
      end

      nxt.emitted_count = e[LEN_W-1:0];

      if (!skip) begin
        if (!ok) begin
          nxt.held_count = 2'd0;
          if (word.in_last) begin
            nxt = '0;
          end else begin
            nxt.discarding = 1'b1;
          end
        end else if (word.in_last) begin
          if (n != 2'd0) begin
            res[n - 2'd1].out_last = 1'b1;
          end
          nxt = '0;
        end
      end
    end

    res_n = n;
  end

endmodule

[sv/pctd_rbuf.sv]
// ----------------------------------------------------------------------------
// pctd_rbuf: result buffer
// holds the result words of one step and, while out_stall is low, hands them out one per cycle
// ----------------------------------------------------------------------------
module pctd_rbuf (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic [1:0]                                load_n,
  input  pctd_pkg::out_word_t [pctd_pkg::RES_DEPTH-1:0] load_res,
  output logic                                      free,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output pctd_pkg::out_word_t                       out_word
);
  import pctd_pkg::*;

  out_word_t [RES_DEPTH-1:0] ent;
  logic [1:0]                cnt;
  logic                      take;

  assign out_valid = (cnt != 2'd0);
  assign out_word  = ent[0];
  assign take      = out_valid && !out_stall;
  // free for a new step once the last word held goes out
  assign free      = (cnt == 2'd0) || (cnt == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_n;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_res;
    end else if (take) begin
      ent <= {ent[RES_DEPTH-1], ent[RES_DEPTH-1:1]};
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == 2'd0 || (cnt == 2'd1 && take)))
    else $error("rbuf loaded while words still pending");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (take && !load) |=> cnt == $past(cnt) - 2'd1)
    else $error("rbuf count did not drop after a word went out");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && load_n != 2'd0) |=> out_valid && out_word == $past(load_res[0]))
    else $error("rbuf did not present the first loaded word");
`endif

endmodule

[sv/percent_escape_decoder_unit.sv]
// ----------------------------------------------------------------------------
// percent_escape_decoder_unit: streaming percent escape decoder
// an accepted word passes the input register, then the result buffer, before
// its first result word shows; throughput: one input word per cycle while
// each gives at most one result and out_stall is low; a word that gives more
// (a malformed escape flush) holds the input until its last result goes out
// reset: synchronous, clears state and buffers, limit register back to 4096
// ----------------------------------------------------------------------------
module percent_escape_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pctd_pkg::in_word_t            in_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output pctd_pkg::out_word_t           out_word,
  // limit register write
  input  logic                          cfg_wr_en,
  input  logic [pctd_pkg::LEN_W-1:0]    cfg_wr_data
);
  import pctd_pkg::*;

  // input register
  logic       in_q_valid;
  in_word_t   in_q;

  // decoder state and limit
  dec_state_t       state;
  logic [LEN_W-1:0] max_out_len;

  // step outputs
  logic [1:0]                step_n;
  out_word_t [RES_DEPTH-1:0] step_res;
  dec_state_t                state_next;

  logic buf_free;
  logic proc_fire;
  logic in_take;

  // a held word is processed as soon as the result buffer can take its words
  assign proc_fire = in_q_valid && buf_free;
  assign in_stall  = in_q_valid && !buf_free;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (proc_fire) begin
      in_q_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_word;
    end
  end

  // decoder state advances once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (proc_fire) begin
      state <= state_next;
    end
  end

  // limit takes effect at once
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MAX_LEN;
    end else if (cfg_wr_en) begin
      max_out_len <= cfg_wr_data;
    end
  end

  pctd_step u_step (
    .cur         (state),
    .max_out_len (max_out_len),
    .word        (in_q),
    .res_n       (step_n),
    .res         (step_res),
    .nxt         (state_next)
  );

  pctd_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (proc_fire),
    .load_n    (step_n),
    .load_res  (step_res),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  // an error word is always zero and closes the string
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status != ST_OK) |-> (out_word.out_last && out_word.out_byte == CH_NUL))
    else $error("error word not zero or not final");

  // after an error every word up to the end of the string is dropped
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && state.discarding) |-> step_n == 2'd0)
    else $error("result produced while discarding");

  // the final word of a string leaves a clean state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && in_q.in_last) |=> (state == '0))
    else $error("state not cleared after final word");
`endif

endmodule
